// ===== hdl/ais_position_sentence_encoder_unit_assert.svh =====
// Assertion macros shared by the AIS sentence encoder modules.
// No dependencies; included by the sequencer and the datapath.
`ifndef AIS_POSITION_SENTENCE_ENCODER_UNIT_ASSERT_SVH
`define AIS_POSITION_SENTENCE_ENCODER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define AISENC_IMPLIES(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("aisenc assertion failed");

// Next-cycle implication, disabled during reset
`define AISENC_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("aisenc assertion failed");

`endif

// ===== hdl/aisenc_pkg.sv =====
// Shared types, constants and the microcode program of the AIS sentence encoder.
// No dependencies; imported by every module of the block.
package aisenc_pkg;

  localparam int IN_TDATA_W  = 128;
  localparam int OUT_TDATA_W = 8;
  localparam int PAY_BITS    = 168;
  localparam int PAY_CHARS   = 28;
  localparam int CHAR_W      = 7;
  localparam int STEP_W      = 5;
  localparam int CNT_W       = $clog2(PAY_CHARS);

  localparam logic [STEP_W-1:0] STEP_FIRST = '0;
  localparam logic [STEP_W-1:0] STEP_PAY   = 5'd14;
  localparam logic [CNT_W-1:0]  CNT_LAST   = CNT_W'(PAY_CHARS - 1);

  // Character source of one microcode step
  typedef enum logic [1:0] {
    SRC_LIT  = 2'd0,
    SRC_PAY  = 2'd1,
    SRC_HEXH = 2'd2,
    SRC_HEXL = 2'd3
  } src_t;

  // One control word
  typedef struct packed {
    src_t              src;
    logic [CHAR_W-1:0] lit;
    logic              xor_en;
    logic              rep;
    logic              last;
  } ucode_t;

  // Character literals
  localparam logic [CHAR_W-1:0] CH_BANG  = 7'h21;
  localparam logic [CHAR_W-1:0] CH_STAR  = 7'h2A;
  localparam logic [CHAR_W-1:0] CH_COMMA = 7'h2C;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CH_ONE   = 7'h31;
  localparam logic [CHAR_W-1:0] CH_A     = 7'h41;
  localparam logic [CHAR_W-1:0] CH_D     = 7'h44;
  localparam logic [CHAR_W-1:0] CH_I     = 7'h49;
  localparam logic [CHAR_W-1:0] CH_M     = 7'h4D;
  localparam logic [CHAR_W-1:0] CH_V     = 7'h56;

  function automatic ucode_t lit_step(logic [CHAR_W-1:0] ch, logic xe);
    ucode_t u;
    u.src    = SRC_LIT;
    u.lit    = ch;
    u.xor_en = xe;
    u.rep    = 1'b0;
    u.last   = 1'b0;
    return u;
  endfunction

  // Program: lead text, payload loop, tail, star and checksum digits
  function automatic ucode_t ucode(logic [STEP_W-1:0] step);
    ucode_t u;
    u = lit_step(CH_COMMA, 1'b0);
    unique case (step)
      5'd0:  u = lit_step(CH_BANG, 1'b0);
      5'd1:  u = lit_step(CH_A, 1'b1);
      5'd2:  u = lit_step(CH_I, 1'b1);
      5'd3:  u = lit_step(CH_V, 1'b1);
      5'd4:  u = lit_step(CH_D, 1'b1);
      5'd5:  u = lit_step(CH_M, 1'b1);
      5'd6:  u = lit_step(CH_COMMA, 1'b1);
      5'd7:  u = lit_step(CH_ONE, 1'b1);
      5'd8:  u = lit_step(CH_COMMA, 1'b1);
      5'd9:  u = lit_step(CH_ONE, 1'b1);
      5'd10: u = lit_step(CH_COMMA, 1'b1);
      5'd11: u = lit_step(CH_COMMA, 1'b1);
      5'd12: u = lit_step(CH_A, 1'b1);
      5'd13: u = lit_step(CH_COMMA, 1'b1);
      5'd14: begin
        u.src    = SRC_PAY;
        u.xor_en = 1'b1;
        u.rep    = 1'b1;
      end
      5'd15: u = lit_step(CH_COMMA, 1'b1);
      5'd16: u = lit_step(CH_ZERO, 1'b1);
      5'd17: u = lit_step(CH_STAR, 1'b0);
      5'd18: u.src = SRC_HEXH;
      5'd19: begin
        u.src  = SRC_HEXL;
        u.last = 1'b1;
      end
      default: u.last = 1'b1;
    endcase
    return u;
  endfunction

  // Uppercase hex digit of a nibble
  function automatic logic [CHAR_W-1:0] hex_digit(logic [3:0] v);
    return (v < 4'd10) ? (CHAR_W'(v) + 7'd48) : (CHAR_W'(v) + 7'd55);
  endfunction

  // Six-bit payload armoring
  function automatic logic [CHAR_W-1:0] armor(logic [5:0] v);
    return (v < 6'd40) ? (CHAR_W'(v) + 7'd48) : (CHAR_W'(v) + 7'd56);
  endfunction

endpackage

// ===== hdl/aisenc_seq.sv =====
// Microcode sequencer: step counter, payload loop counter and control word fetch.
// Depends on aisenc_pkg and the assertion macro header.
`include "ais_position_sentence_encoder_unit_assert.svh"

module aisenc_seq
  import aisenc_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   start,
  input  logic   adv,
  output logic   busy,
  output ucode_t ctrl
);

  logic              busy_r, busy_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  // Fetch the control word of the current step
  assign ctrl = ucode(step_r);
  assign busy = busy_r;

  // Start at the first step, advance the step, repeat the payload step, stop after the last one
  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    cnt_nxt  = cnt_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = STEP_FIRST;
      cnt_nxt  = '0;
    end else if (adv) begin
      if (ctrl.last) begin
        busy_nxt = 1'b0;
        step_nxt = STEP_FIRST;
        cnt_nxt  = '0;
      end else if (ctrl.rep && (cnt_r != CNT_LAST)) begin
        cnt_nxt = cnt_r + 1'b1;
      end else begin
        cnt_nxt  = '0;
        step_nxt = step_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= STEP_FIRST;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  `AISENC_IMPLIES(a_idle_at_origin, clk, rst_n, !busy_r, (step_r == STEP_FIRST) && (cnt_r == '0))
  `AISENC_IMPLIES(a_cnt_only_in_loop, clk, rst_n, cnt_r != '0, step_r == STEP_PAY)
  `AISENC_NEXT(a_busy_holds, clk, rst_n, busy_r && !adv, busy_r)

endmodule

// ===== hdl/aisenc_dp.sv =====
// Datapath: payload register, armoring, checksum and the output register.
// Depends on aisenc_pkg and the assertion macro header.
`include "ais_position_sentence_encoder_unit_assert.svh"

module aisenc_dp
  import aisenc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  logic              adv,
  input  ucode_t            ctrl,
  input  logic              command,
  input  logic [29:0]       vessel_id,
  input  logic [3:0]        nav_status,
  input  logic [9:0]        speed_tenths,
  input  logic              accuracy_flag,
  input  logic signed [27:0] longitude_units,
  input  logic signed [26:0] latitude_units,
  input  logic [11:0]       course_tenths,
  input  logic [8:0]        heading_deg,
  input  logic [5:0]        utc_second,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CHAR_W-1:0] out_char,
  output logic              out_last
);

  logic [PAY_BITS-1:0] pay_r, pay_nxt;
  logic [PAY_BITS-1:0] pay_load;
  logic [CHAR_W-1:0]   xor_r, xor_nxt;
  logic [CHAR_W-1:0]   ch;
  logic                out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]   out_char_r;
  logic                out_last_r;

  // Build the 168-bit payload of either report type
  always_comb begin
    if (command) begin
      pay_load = {6'd18, 2'b00, vessel_id, 8'd0, speed_tenths, accuracy_flag,
                  longitude_units, latitude_units, course_tenths, heading_deg,
                  utc_second, 29'd0};
    end else begin
      pay_load = {6'd1, 2'b00, vessel_id, nav_status, 8'd128, speed_tenths, 1'b0,
                  longitude_units, latitude_units, course_tenths, heading_deg,
                  utc_second, 25'd0};
    end
  end

  // Select the character of the current step
  always_comb begin
    case (ctrl.src)
      SRC_PAY:  ch = armor(pay_r[PAY_BITS-1 -: 6]);
      SRC_HEXH: ch = hex_digit({1'b0, xor_r[6:4]});
      SRC_HEXL: ch = hex_digit(xor_r[3:0]);
      default:  ch = ctrl.lit;
    endcase
  end

  // Load or shift the payload, clear or accumulate the checksum
  always_comb begin
    pay_nxt = pay_r;
    xor_nxt = xor_r;
    if (load) begin
      pay_nxt = pay_load;
      xor_nxt = '0;
    end else if (adv) begin
      if (ctrl.src == SRC_PAY) begin
        pay_nxt = {pay_r[PAY_BITS-7:0], 6'd0};
      end
      if (ctrl.xor_en) begin
        xor_nxt = xor_r ^ ch;
      end
    end
  end

  // Hold a character until the sink takes it
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pay_r       <= '0;
      xor_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      pay_r       <= pay_nxt;
      xor_r       <= xor_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_char_r <= ch;
      out_last_r <= ctrl.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;

  `AISENC_NEXT(a_load_clears_xor, clk, rst_n, load, xor_r == '0)
  `AISENC_NEXT(a_adv_fills_out, clk, rst_n, adv, out_valid_r)
  `AISENC_IMPLIES(a_last_is_hex, clk, rst_n, out_valid_r && out_last_r,
    ((out_char_r >= 7'd48) && (out_char_r <= 7'd57)) ||
    ((out_char_r >= 7'd65) && (out_char_r <= 7'd70)))

endmodule

// ===== hdl/ais_position_sentence_encoder_unit.sv =====
// AIS position sentence encoder: one report in, 47 AIVDM characters out.
// Throughput: one character per cycle while the output is not stalled; a new report is
// accepted while the last character of the previous sentence is stepped.
// Reset: synchronous active-low rst_n idles the sequencer and empties the output.
// Depends on aisenc_pkg, aisenc_seq and aisenc_dp.
module ais_position_sentence_encoder_unit
  import aisenc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [29:0] vessel_id, [33:30] nav_status, [43:34] speed_tenths,
  // [44] accuracy_flag, [72:45] longitude_units, [99:73] latitude_units,
  // [111:100] course_tenths, [120:112] heading_deg, [126:121] utc_second
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // [0] command
  input  logic                   in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [6:0] sentence_char
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast
);

  logic              busy;
  logic              adv;
  logic              start;
  ucode_t            ctrl;
  logic [CHAR_W-1:0] out_char;

  // Step when the output register is free or being drained
  assign adv       = busy && (!out_tvalid || out_tready);
  assign in_tready = !busy || (ctrl.last && adv);
  assign start     = in_tvalid && in_tready;

  aisenc_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .adv   (adv),
    .busy  (busy),
    .ctrl  (ctrl)
  );

  aisenc_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (start),
    .adv             (adv),
    .ctrl            (ctrl),
    .command         (in_tuser),
    .vessel_id       (in_tdata[29:0]),
    .nav_status      (in_tdata[33:30]),
    .speed_tenths    (in_tdata[43:34]),
    .accuracy_flag   (in_tdata[44]),
    .longitude_units (in_tdata[72:45]),
    .latitude_units  (in_tdata[99:73]),
    .course_tenths   (in_tdata[111:100]),
    .heading_deg     (in_tdata[120:112]),
    .utc_second      (in_tdata[126:121]),
    .out_valid       (out_tvalid),
    .out_ready       (out_tready),
    .out_char        (out_char),
    .out_last        (out_tlast)
  );

  assign out_tdata = {1'b0, out_char};

endmodule

// ===== dv/ais_report_pkg.sv =====
// Report kinds and the packed position report fields shared by the AIS encoder testbench.
// No dependencies; imported by the checker and the testbench top.
package ais_report_pkg;

  // in_tuser selects the AIS message built from the report
  typedef enum logic {
    CMD_CLASS_A = 1'b0,
    CMD_CLASS_B = 1'b1
  } report_kind_t;

  // Layout of in_tdata, highest field first; the top bit is unused and held at zero
  typedef struct packed {
    logic        pad;
    logic [5:0]  second;
    logic [8:0]  heading;
    logic [11:0] course;
    logic [26:0] lat;
    logic [27:0] lon;
    logic        accuracy;
    logic [9:0]  speed;
    logic [3:0]  status;
    logic [29:0] vessel;
  } report_fields_t;

endpackage

// ===== dv/ais_sentence_checker.sv =====
// Checker for the AIS position sentence encoder: predicts each AIVDM sentence from the
// accepted report and compares every character transfer. Depends on aisenc_pkg and
// ais_report_pkg.
module ais_sentence_checker
  import aisenc_pkg::*;
  import ais_report_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   out_tlast,
  output int                     fail_count,
  output int                     pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [8*14-1:0]   LEAD_TEXT       = "!AIVDM,1,1,,A,";
  localparam logic [8*2-1:0]    TAIL_TEXT       = ",0";
  localparam logic [CHAR_W-1:0] STAR_CHAR       = 7'h2A;
  localparam logic [5:0]        MSG_ID_CLASS_A  = 6'd1;
  localparam logic [5:0]        MSG_ID_CLASS_B  = 6'd18;
  localparam logic [7:0]        ROT_UNAVAILABLE = 8'd128;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } sentence_char_t;

  sentence_char_t sentence_q[$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // 168-bit payload, first transmitted bit in the MSB; spare and radio bits are zero
  function automatic logic [PAY_BITS-1:0] position_payload(report_kind_t kind,
                                                           report_fields_t f);
    if (kind == CMD_CLASS_A)
      return {MSG_ID_CLASS_A, 2'd0, f.vessel, f.status, ROT_UNAVAILABLE, f.speed, 1'b0,
              f.lon, f.lat, f.course, f.heading, f.second, 25'd0};
    return {MSG_ID_CLASS_B, 2'd0, f.vessel, 8'd0, f.speed, f.accuracy, f.lon, f.lat,
            f.course, f.heading, f.second, 29'd0};
  endfunction

  function automatic logic [CHAR_W-1:0] hex_char(logic [3:0] n);
    return (n < 4'd10) ? {3'b000, n} + 7'h30 : {3'b000, n} + 7'h37;
  endfunction

  task automatic add_char(logic [CHAR_W-1:0] c, logic last);
    sentence_char_t e;
    e.ch   = c;
    e.last = last;
    sentence_q.push_back(e);
  endtask

  // Queue the 47 characters of one sentence
  task automatic queue_sentence(report_kind_t kind, report_fields_t f);
    logic [PAY_BITS-1:0] bits;
    logic [7:0]          sum;
    logic [CHAR_W-1:0]   c;
    logic [5:0]          six;
    bits = position_payload(kind, f);
    sum  = '0;
    for (int i = 0; i < 14; i++) begin
      c = LEAD_TEXT[8*(13-i) +: CHAR_W];
      // checksum starts after the leading '!'
      if (i != 0) sum ^= {1'b0, c};
      add_char(c, 1'b0);
    end
    // armor six bits per character
    for (int i = 0; i < PAY_CHARS; i++) begin
      six = bits[PAY_BITS-1-6*i -: 6];
      c   = (six < 6'd40) ? {1'b0, six} + 7'd48 : {1'b0, six} + 7'd56;
      sum ^= {1'b0, c};
      add_char(c, 1'b0);
    end
    for (int i = 0; i < 2; i++) begin
      c = TAIL_TEXT[8*(1-i) +: CHAR_W];
      sum ^= {1'b0, c};
      add_char(c, 1'b0);
    end
    add_char(STAR_CHAR, 1'b0);
    add_char(hex_char(sum[7:4]), 1'b0);
    add_char(hex_char(sum[3:0]), 1'b1);
  endtask

  // Compare character transfers first, then queue the sentence of a new report
  always @(posedge clk) begin
    sentence_char_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (sentence_q.size() == 0) begin
          $display("%0t: unexpected transfer tdata=%h tlast=%b, nothing pending",
                   $time, out_tdata, out_tlast);
          fail_count++;
        end else begin
          want = sentence_q.pop_front();
          if (out_tdata !== OUT_TDATA_W'(want.ch) || out_tlast !== want.last) begin
            $display("%0t: expected tdata=%h tlast=%b, actual tdata=%h tlast=%b",
                     $time, OUT_TDATA_W'(want.ch), want.last, out_tdata, out_tlast);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready)
        queue_sentence(report_kind_t'(in_tuser), report_fields_t'(in_tdata));
    end
    pending <= sentence_q.size();
  end

endmodule

// ===== dv/testbench.sv =====
// Top of the AIS position sentence encoder testbench: clock, reset, report stimulus,
// output back-pressure, watchdog and verdict. Depends on the encoder RTL, aisenc_pkg,
// ais_report_pkg and ais_sentence_checker.
module testbench
  import aisenc_pkg::*;
  import ais_report_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          RANDOM_REPORTS        = 250;
  localparam int          IDLE_LIMIT            = 2000;
  localparam int          DRAIN_CYCLES          = 50;
  localparam logic [8:0]  HEADING_NOT_AVAILABLE = 9'd511;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;

  int fail_count;
  int pending;
  int idle_run = 0;
  int ready_gap;
  bit steady = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  ais_position_sentence_encoder_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  ais_sentence_checker sentence_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Mostly no gap, often a short one, now and then a long one
  function automatic int idle_cycles();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Mostly realistic reports; a quarter keep raw random bits in every field
  function automatic report_fields_t random_fields();
    report_fields_t f;
    f     = {$urandom(), $urandom(), $urandom(), $urandom()};
    f.pad = 1'b0;
    if ($urandom_range(0, 3) != 0) begin
      f.vessel = 30'($urandom_range(0, 999999999));
      f.lon    = 28'(int'($urandom_range(0, 216000000)) - 108000000);
      f.lat    = 27'(int'($urandom_range(0, 108000000)) - 54000000);
      f.course = 12'($urandom_range(0, 3600));
      f.second = 6'($urandom_range(0, 59));
      if ($urandom_range(0, 4) == 0) f.heading = HEADING_NOT_AVAILABLE;
      else f.heading = 9'($urandom_range(0, 359));
    end
    return f;
  endfunction

  // Present one report and hold it until the transfer
  task automatic send_report(report_kind_t kind, report_fields_t f);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= f;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Hold off the sender until every queued character has arrived
  task automatic drain_sentences();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Output back-pressure: bursts of ready broken by random stalls
  initial begin
    out_tready <= 1'b0;
    @(posedge clk);
    forever begin
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
      ready_gap = idle_cycles();
      if (ready_gap > 0) begin
        out_tready <= 1'b0;
        repeat (ready_gap) @(posedge clk);
      end
    end
  end

  // Watchdog on stretches without any transfer
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_run <= 0;
    else idle_run <= idle_run + 1;
    if (idle_run >= IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin
    report_fields_t f;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tuser  <= CMD_CLASS_A;
    in_tdata  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: zero and all-ones fields for both kinds, back to back
    steady = 1'b1;
    f = '0;
    send_report(CMD_CLASS_A, f);
    send_report(CMD_CLASS_B, f);
    f = '1;
    f.pad = 1'b0;
    send_report(CMD_CLASS_A, f);
    send_report(CMD_CLASS_B, f);
    // alternating bit patterns
    f = {64{2'b01}};
    f.pad = 1'b0;
    send_report(CMD_CLASS_A, f);
    send_report(CMD_CLASS_B, f);
    steady = 1'b0;
    f = {64{2'b10}};
    f.pad = 1'b0;
    send_report(CMD_CLASS_A, f);
    send_report(CMD_CLASS_B, f);

    // Range extremes; class A drops the accuracy flag, class B the nav status
    f.pad      = 1'b0;
    f.vessel   = 30'd999999999;
    f.status   = 4'd15;
    f.speed    = 10'd1022;
    f.accuracy = 1'b1;
    f.lon      = 28'(108000000);
    f.lat      = 27'(54000000);
    f.course   = 12'd3600;
    f.heading  = 9'd359;
    f.second   = 6'd59;
    send_report(CMD_CLASS_A, f);
    send_report(CMD_CLASS_B, f);
    f.lon      = 28'(-108000000);
    f.lat      = 27'(-54000000);
    f.speed    = 10'd1023;
    f.heading  = HEADING_NOT_AVAILABLE;
    f.second   = 6'd60;
    f.accuracy = 1'b0;
    send_report(CMD_CLASS_B, f);
    send_report(CMD_CLASS_A, f);
    // just below zero, MMSI above the nine-digit range, zero heading
    f.lon     = 28'(-1);
    f.lat     = 27'(-1);
    f.vessel  = 30'd1000000000;
    f.heading = 9'd0;
    f.status  = 4'd0;
    send_report(CMD_CLASS_A, f);
    f.accuracy = 1'b1;
    send_report(CMD_CLASS_B, f);
    drain_sentences();

    // Random reports, with a stretch of no idling and one full drain
    for (int n = 0; n < RANDOM_REPORTS; n++) begin
      steady = (n >= 100 && n < 140);
      if (n == 180) drain_sentences();
      send_report($urandom_range(0, 1) ? CMD_CLASS_B : CMD_CLASS_A, random_fields());
    end

    drain_sentences();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/aisenc_pkg.sv
hdl/aisenc_seq.sv
hdl/aisenc_dp.sv
hdl/ais_position_sentence_encoder_unit.sv
dv/ais_report_pkg.sv
dv/ais_sentence_checker.sv
dv/testbench.sv
